[hdl/cddn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cddn_pkg;

    // Highest calendar year accepted or produced
    localparam int YEAR_MAX = 9999;

    // Field widths
    localparam int OP_W    = 2;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int LIN_W   = 23;
    localparam int SEC_W   = 39;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DNUM = 2'd1;
    localparam logic [OP_W-1:0] OP_SECS = 2'd2;

    // Month codes
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // Calendar block lengths in days, and seconds per day
    localparam int SEC_DAY  = 86400;
    localparam int ERA_DAYS = 146097;
    localparam int CEN_DAYS = 36524;
    localparam int BLK_DAYS = 1461;
    localparam int YR_DAYS  = 365;

    // Days from 1 Jan of year 1 up to 1 Jan of year y (elaboration only)
    function automatic int days_before(input int y);
        int p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    // Internal day index z counts from 1 Jan of year 1
    localparam int EPOCH_Z = days_before(1970);
    localparam int Z_MAX   = days_before(YEAR_MAX + 1) - 1;
    localparam int ERA_W   = $clog2(YEAR_MAX / 400 + 1);

    // Seconds are biased to a nonnegative value before the divide
    localparam longint SEC_HALF     = longint'(1) << (SEC_W - 1);
    localparam longint SEC_OFS_DAYS = (SEC_HALF + SEC_DAY - 1) / SEC_DAY;
    localparam longint U_OFS        = SEC_OFS_DAYS * SEC_DAY;
    localparam longint U_MAX        = SEC_HALF - 1 + U_OFS;
    localparam int     ALU_W        = $clog2(U_MAX + 1) + 1;
    localparam int     SQ_W         = $clog2(U_MAX / SEC_DAY + 1);
    localparam int     BIT_W        = $clog2((SQ_W > ERA_W) ? SQ_W : ERA_W);

    // Decomposition levels: 400 years, 100 years, 4 years, 1 year
    typedef enum logic [1:0] {
        L_ERA = 2'd0,
        L_CEN = 2'd1,
        L_BLK = 2'd2,
        L_YR  = 2'd3
    } t_lvl;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic                    go;
        logic                    ok;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic signed [LIN_W-1:0] lin;
    } t_fin;

    function automatic logic [ALU_W-1:0] lvl_days(input t_lvl l);
        case (l)
            L_ERA:   return ALU_W'(ERA_DAYS);
            L_CEN:   return ALU_W'(CEN_DAYS);
            L_BLK:   return ALU_W'(BLK_DAYS);
            default: return ALU_W'(YR_DAYS);
        endcase
    endfunction

    function automatic logic [YEAR_W-1:0] lvl_years(input t_lvl l);
        case (l)
            L_ERA:   return YEAR_W'(400);
            L_CEN:   return YEAR_W'(100);
            L_BLK:   return YEAR_W'(4);
            default: return YEAR_W'(1);
        endcase
    endfunction

    // MSB of the quotient taken at each level
    function automatic logic [BIT_W-1:0] lvl_top(input t_lvl l);
        case (l)
            L_ERA:   return BIT_W'(ERA_W - 1);
            L_CEN:   return BIT_W'(1);
            L_BLK:   return BIT_W'(4);
            default: return BIT_W'(1);
        endcase
    endfunction

    // Leap year from the position inside the era: last year of a 4-year
    // block, except the last block of a century that is not the fourth one
    function automatic logic is_leap(input logic [1:0] cen, input logic [4:0] blk,
                                     input logic [1:0] yr);
        return (yr == 2'd3) && ((blk != 5'd24) || (cen == 2'd3));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        case (m)
            MON_FEB: return leap ? DAY_W'(29) : DAY_W'(28);
            MON_APR: return DAY_W'(30);
            MON_JUN: return DAY_W'(30);
            MON_SEP: return DAY_W'(30);
            MON_NOV: return DAY_W'(30);
            default: return DAY_W'(31);
        endcase
    endfunction

    function automatic logic [YEAR_W-1:0] year_of(input logic [ERA_W-1:0] e,
                                                  input logic [1:0] c,
                                                  input logic [4:0] f,
                                                  input logic [1:0] g);
        return YEAR_W'(e) * YEAR_W'(400) + YEAR_W'(c) * YEAR_W'(100)
             + YEAR_W'({f, 2'b00}) + YEAR_W'(g) + YEAR_W'(1);
    endfunction

endpackage
`default_nettype wire

[hdl/cddn_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
module cddn_alu import cddn_pkg::*; (
    input  t_alu_req          i_req,
    output logic [ALU_W-1:0]  o_res
);

    // Single adder; subtract as a + ~b + 1
    logic [ALU_W-1:0] w_b;

    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_res = i_req.a + w_b + ALU_W'(i_req.sub);

endmodule
`default_nettype wire

[hdl/cddn_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module cddn_core import cddn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [YEAR_W-1:0]       i_year,
    input  logic [MONTH_W-1:0]      i_month,
    input  logic [DAY_W-1:0]        i_day_of_month,
    input  logic signed [LIN_W-1:0] i_day_number,
    input  logic signed [SEC_W-1:0] i_seconds,
    output logic                    o_busy,
    output t_fin                    o_fin
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LOAD  = 14'b00000000000010,
        S_SDIV  = 14'b00000000000100,
        S_SFIN  = 14'b00000000001000,
        S_ZSET  = 14'b00000000010000,
        S_DTRY  = 14'b00000000100000,
        S_MSTEP = 14'b00000001000000,
        S_YTRY  = 14'b00000010000000,
        S_YADD  = 14'b00000100000000,
        S_DCHK  = 14'b00001000000000,
        S_MADD  = 14'b00010000000000,
        S_DADD  = 14'b00100000000000,
        S_LSET  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_state;

    t_state                  r_state, n_state;
    logic [OP_W-1:0]         r_op, n_op;
    logic [YEAR_W-1:0]       r_year, n_year;
    logic [MONTH_W-1:0]      r_month, n_month;
    logic [DAY_W-1:0]        r_day, n_day;
    logic signed [LIN_W-1:0] r_lin, n_lin;
    logic [ALU_W-1:0]        r_acc, n_acc;
    logic [SQ_W-1:0]         r_quo, n_quo;
    logic [YEAR_W-1:0]       r_yrem, n_yrem;
    t_lvl                    r_lvl, n_lvl;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [ERA_W-1:0]        r_qe, n_qe;
    logic [1:0]              r_qc, n_qc;
    logic [4:0]              r_qf, n_qf;
    logic [1:0]              r_qg, n_qg;
    logic [MONTH_W-1:0]      r_mcnt, n_mcnt;
    logic                    r_ok, n_ok;

    t_alu_req                w_req;
    logic [ALU_W-1:0]        w_res;
    logic                    w_take;
    logic                    w_leap;
    logic                    w_last_bit;
    logic                    w_lvl_done;
    t_lvl                    w_nxt_lvl;
    logic                    w_date_ok;
    logic                    w_dn_pos;

    cddn_alu u_alu (
        .i_req (w_req),
        .o_res (w_res)
    );

    // Trial subtract succeeds when no borrow comes out
    assign w_take     = ~w_res[ALU_W-1];
    assign w_leap     = is_leap(r_qc, r_qf, r_qg);
    assign w_last_bit = (r_bit == '0);
    assign w_lvl_done = w_last_bit && (r_lvl == L_YR);
    assign w_nxt_lvl  = t_lvl'(r_lvl + 2'd1);
    assign w_date_ok  = (r_year != '0) && (r_year <= YEAR_W'(YEAR_MAX))
                     && (r_month >= MON_JAN) && (r_month <= MON_DEC)
                     && (r_day != '0);
    assign w_dn_pos   = ~r_lin[LIN_W-1] && (r_lin != '0);

    // Sequencer and operand selection for the shared unit
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_lin   = r_lin;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_yrem  = r_yrem;
        n_lvl   = r_lvl;
        n_bit   = r_bit;
        n_qe    = r_qe;
        n_qc    = r_qc;
        n_qf    = r_qf;
        n_qg    = r_qg;
        n_mcnt  = r_mcnt;
        n_ok    = r_ok;
        w_req.a   = r_acc;
        w_req.b   = '0;
        w_req.sub = 1'b0;

        // Level quotients fill MSB first, one trial per cycle; a taken year trial also passes through S_YADD
        if ((r_state == S_DTRY) || (r_state == S_YTRY)) begin
            case (r_lvl)
                L_ERA:   n_qe = {r_qe[ERA_W-2:0], w_take};
                L_CEN:   n_qc = {r_qc[0], w_take};
                L_BLK:   n_qf = {r_qf[3:0], w_take};
                default: n_qg = {r_qg[0], w_take};
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_operation;
                    n_year  = i_year;
                    n_month = i_month;
                    n_day   = i_day_of_month;
                    n_lin   = i_day_number;
                    n_acc   = ALU_W'(i_seconds);
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                case (r_op)
                    OP_DATE: begin
                        if (w_date_ok) begin
                            n_yrem  = r_year - YEAR_W'(1);
                            n_acc   = '0;
                            n_lvl   = L_ERA;
                            n_bit   = lvl_top(L_ERA);
                            n_state = S_YTRY;
                        end else begin
                            n_ok    = 1'b0;
                            n_state = S_FIN;
                        end
                    end
                    OP_DNUM: begin
                        // positive day numbers skip the missing day zero
                        w_req.a   = ALU_W'(r_lin);
                        w_req.b   = ALU_W'(w_dn_pos);
                        w_req.sub = 1'b1;
                        n_lin     = w_res[LIN_W-1:0];
                        if (r_lin == '0) begin
                            n_ok    = 1'b0;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_ZSET;
                        end
                    end
                    OP_SECS: begin
                        w_req.a = r_acc;
                        w_req.b = ALU_W'(U_OFS);
                        n_acc   = w_res;
                        n_quo   = '0;
                        n_bit   = BIT_W'(SQ_W - 1);
                        n_state = S_SDIV;
                    end
                    default: begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SDIV: begin
                // restoring divide by seconds per day
                w_req.b   = ALU_W'(SEC_DAY) << r_bit;
                w_req.sub = 1'b1;
                if (w_take) begin
                    n_acc = w_res;
                end
                n_quo = {r_quo[SQ_W-2:0], w_take};
                if (w_last_bit) begin
                    n_state = S_SFIN;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_SFIN: begin
                w_req.a   = ALU_W'(r_quo);
                w_req.b   = ALU_W'(SEC_OFS_DAYS);
                w_req.sub = 1'b1;
                n_lin     = w_res[LIN_W-1:0];
                n_state   = S_ZSET;
            end
            S_ZSET: begin
                // shift to day index and range check
                w_req.a = ALU_W'(r_lin);
                w_req.b = ALU_W'(EPOCH_Z);
                n_acc   = w_res;
                if (w_res[ALU_W-1] || (w_res > ALU_W'(Z_MAX))) begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_lvl   = L_ERA;
                    n_bit   = lvl_top(L_ERA);
                    n_state = S_DTRY;
                end
            end
            S_DTRY: begin
                w_req.b   = lvl_days(r_lvl) << r_bit;
                w_req.sub = 1'b1;
                if (w_take) begin
                    n_acc = w_res;
                end
                if (w_lvl_done) begin
                    n_month = MON_JAN;
                    n_state = S_MSTEP;
                end else if (w_last_bit) begin
                    n_lvl = w_nxt_lvl;
                    n_bit = lvl_top(w_nxt_lvl);
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_MSTEP: begin
                w_req.b   = ALU_W'(month_len(r_month, w_leap));
                w_req.sub = 1'b1;
                if (w_take) begin
                    n_acc   = w_res;
                    n_month = r_month + MONTH_W'(1);
                end else begin
                    n_day   = r_acc[DAY_W-1:0] + DAY_W'(1);
                    n_year  = year_of(r_qe, r_qc, r_qf, r_qg);
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_YTRY: begin
                // split year-1 into eras, centuries, blocks and years
                w_req.a   = ALU_W'(r_yrem);
                w_req.b   = ALU_W'(lvl_years(r_lvl)) << r_bit;
                w_req.sub = 1'b1;
                if (w_take) begin
                    n_yrem  = w_res[YEAR_W-1:0];
                    n_state = S_YADD;
                end else if (w_lvl_done) begin
                    n_state = S_DCHK;
                end else if (w_last_bit) begin
                    n_lvl = w_nxt_lvl;
                    n_bit = lvl_top(w_nxt_lvl);
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_YADD: begin
                // accumulate the days of the block just taken
                w_req.b = lvl_days(r_lvl) << r_bit;
                n_acc   = w_res;
                if (w_lvl_done) begin
                    n_state = S_DCHK;
                end else begin
                    n_state = S_YTRY;
                    if (w_last_bit) begin
                        n_lvl = w_nxt_lvl;
                        n_bit = lvl_top(w_nxt_lvl);
                    end else begin
                        n_bit = r_bit - BIT_W'(1);
                    end
                end
            end
            S_DCHK: begin
                if (r_day <= month_len(r_month, w_leap)) begin
                    n_mcnt  = MON_JAN;
                    n_state = S_MADD;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_MADD: begin
                w_req.b = ALU_W'(month_len(r_mcnt, w_leap));
                if (r_mcnt == r_month) begin
                    n_state = S_DADD;
                end else begin
                    n_acc  = w_res;
                    n_mcnt = r_mcnt + MONTH_W'(1);
                end
            end
            S_DADD: begin
                w_req.b = ALU_W'(r_day - DAY_W'(1));
                n_acc   = w_res;
                n_state = S_LSET;
            end
            S_LSET: begin
                w_req.b   = ALU_W'(EPOCH_Z);
                w_req.sub = 1'b1;
                n_lin     = w_res[LIN_W-1:0];
                n_ok      = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_lin   <= n_lin;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_yrem  <= n_yrem;
        r_lvl   <= n_lvl;
        r_bit   <= n_bit;
        r_qe    <= n_qe;
        r_qc    <= n_qc;
        r_qf    <= n_qf;
        r_qg    <= n_qg;
        r_mcnt  <= n_mcnt;
        r_ok    <= n_ok;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_fin.go    = (r_state == S_FIN);
    assign o_fin.ok    = r_ok;
    assign o_fin.year  = r_year;
    assign o_fin.month = r_month;
    assign o_fin.day   = r_day;
    assign o_fin.lin   = r_lin;

endmodule
`default_nettype wire

[hdl/cddn_out.sv]
`timescale 1ns / 1ps
`default_nettype none
module cddn_out import cddn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fin                    i_fin,
    output logic                    o_done,
    output logic [YEAR_W-1:0]       o_year,
    output logic [MONTH_W-1:0]      o_month,
    output logic [DAY_W-1:0]        o_day,
    output logic signed [LIN_W-1:0] o_day_number,
    output logic signed [SEC_W-1:0] o_seconds,
    output logic                    o_valid
);

    localparam int PROD_W = LIN_W + 18;

    logic                    r_done;
    logic [YEAR_W-1:0]       r_year;
    logic [MONTH_W-1:0]      r_month;
    logic [DAY_W-1:0]        r_day;
    logic signed [LIN_W-1:0] r_dn;
    logic signed [SEC_W-1:0] r_sec;
    logic                    r_valid;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [LIN_W-1:0]  w_dn;

    // Start second of the day, and the day number without day zero
    assign w_prod = PROD_W'(i_fin.lin) * PROD_W'(SEC_DAY);
    assign w_dn   = i_fin.lin[LIN_W-1] ? i_fin.lin : i_fin.lin + LIN_W'(1);

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_fin.go;
        end
    end

    // Result beat, all zero when invalid
    always_ff @(posedge i_clk) begin
        if (i_fin.go) begin
            r_valid <= i_fin.ok;
            r_year  <= i_fin.ok ? i_fin.year  : '0;
            r_month <= i_fin.ok ? i_fin.month : '0;
            r_day   <= i_fin.ok ? i_fin.day   : '0;
            r_dn    <= i_fin.ok ? w_dn        : '0;
            r_sec   <= i_fin.ok ? w_prod[SEC_W-1:0] : '0;
        end
    end

    assign o_done       = r_done;
    assign o_year       = r_year;
    assign o_month      = r_month;
    assign o_day        = r_day;
    assign o_day_number = r_dn;
    assign o_seconds    = r_sec;
    assign o_valid      = r_valid;

endmodule
`default_nettype wire

[hdl/civil_date_day_number_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Converts a proleptic Gregorian date, a day number (1 Jan 1970 is day 1, 31 Dec 1969
// is day -1, no day 0) or a count of seconds since 1970 into date, day number and
// start second of the day. Pulse start while busy is low; busy stays high until the
// result, which is shown for exactly one cycle with o_done high and cannot be held
// off, so the receiver must take it then. The time to the result strobe varies with
// the operation, the month and the calendar position, and invalid input finishes
// early. Busy falls in the strobe cycle, so the next beat can be taken at the edge
// that ends it. One shared add/subtract unit produces one quotient bit of the seconds
// divide, one step of the 400/100/4/1-year split, or one month step per cycle; a taken
// year step of a date input also passes through S_YADD. Invalid input gives
// o_valid_res low and all fields zero.
module civil_date_day_number_converter import cddn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [YEAR_W-1:0]       i_year,
    input  logic [MONTH_W-1:0]      i_month,
    input  logic [DAY_W-1:0]        i_day_of_month,
    input  logic signed [LIN_W-1:0] i_day_number,
    input  logic signed [SEC_W-1:0] i_seconds,
    output logic                    o_done,
    output logic [YEAR_W-1:0]       o_out_year,
    output logic [MONTH_W-1:0]      o_out_month,
    output logic [DAY_W-1:0]        o_out_day,
    output logic signed [LIN_W-1:0] o_out_day_number,
    output logic signed [SEC_W-1:0] o_out_seconds,
    output logic                    o_valid_res
);

    t_fin w_fin;

    // Sequencer with the shared arithmetic unit
    cddn_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_year         (i_year),
        .i_month        (i_month),
        .i_day_of_month (i_day_of_month),
        .i_day_number   (i_day_number),
        .i_seconds      (i_seconds),
        .o_busy         (busy),
        .o_fin          (w_fin)
    );

    // Result formatting and output register
    cddn_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fin        (w_fin),
        .o_done       (o_done),
        .o_year       (o_out_year),
        .o_month      (o_out_month),
        .o_day        (o_out_day),
        .o_day_number (o_out_day_number),
        .o_seconds    (o_out_seconds),
        .o_valid      (o_valid_res)
    );

    // Accepted beat keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    // Result appears only after the sequencer went idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // Invalid result has zero year, month and day number
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |->
            (o_out_year == '0) && (o_out_month == '0) && (o_out_day_number == '0))
        else $error("invalid result not cleared");

    // Valid result carries a real month and day
    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |->
            (o_out_month >= MON_JAN) && (o_out_month <= MON_DEC) && (o_out_day != '0))
        else $error("valid result with bad month or day");

endmodule
`default_nettype wire

[bench/tb_civil_date_day_number_converter.sv]
`timescale 1ns / 1ps
module tb_civil_date_day_number_converter import cddn_pkg::*;;

    // Selector value the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Days from 1 Mar of year 0 to 1 Jan 1970
    localparam longint DAYS_TO_EPOCH = 719468;
    // Linear day range of years 1..YEAR_MAX, 1 Jan 1970 as 0
    localparam longint LIN_FIRST = -719162;
    localparam longint LIN_LAST  = 2932896;
    localparam longint SEC_FIRST = LIN_FIRST * SEC_DAY;
    localparam longint SEC_LAST  = (LIN_LAST + 1) * SEC_DAY - 1;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        dom;
        logic signed [LIN_W-1:0] dnum;
        logic signed [SEC_W-1:0] secs;
    } t_civil_item;

    typedef struct packed {
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic signed [LIN_W-1:0] dnum;
        logic signed [SEC_W-1:0] secs;
        logic                    ok;
    } t_civil_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_operation;
    logic [YEAR_W-1:0]       i_year;
    logic [MONTH_W-1:0]      i_month;
    logic [DAY_W-1:0]        i_day_of_month;
    logic signed [LIN_W-1:0] i_day_number;
    logic signed [SEC_W-1:0] i_seconds;
    logic                    o_done;
    logic [YEAR_W-1:0]       o_out_year;
    logic [MONTH_W-1:0]      o_out_month;
    logic [DAY_W-1:0]        o_out_day;
    logic signed [LIN_W-1:0] o_out_day_number;
    logic signed [SEC_W-1:0] o_out_seconds;
    logic                    o_valid_res;

    t_civil_result expected_dates[$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            burst_left     = 0;

    civil_date_day_number_converter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_year           (i_year),
        .i_month          (i_month),
        .i_day_of_month   (i_day_of_month),
        .i_day_number     (i_day_number),
        .i_seconds        (i_seconds),
        .o_done           (o_done),
        .o_out_year       (o_out_year),
        .o_out_month      (o_out_month),
        .o_out_day        (o_out_day),
        .o_out_day_number (o_out_day_number),
        .o_out_seconds    (o_out_seconds),
        .o_valid_res      (o_valid_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- calendar arithmetic ----------------

    function automatic longint month_days(input longint y, input longint m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m == MON_FEB) return leap ? 29 : 28;
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) return 30;
        return 31;
    endfunction

    // Days since 1 Jan 1970 (that date is 0); year counted from March
    function automatic longint days_from_civil(input longint y, input longint m,
                                               input longint d);
        longint yy, era, yoe, mp, doy, doe;
        yy  = y - ((m <= 2) ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * ERA_DAYS + doe - DAYS_TO_EPOCH;
    endfunction

    function automatic void civil_from_days(input longint lin, output longint y,
                                            output longint m, output longint d);
        longint z, era, doe, yoe, doy, mp;
        z   = lin + DAYS_TO_EPOCH;
        era = z / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        d   = doy - (153 * mp + 2) / 5 + 1;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    // Expected conversion of one beat; invalid input gives all zeros
    function automatic t_civil_result predict_civil_result(input t_civil_item item);
        t_civil_result r;
        longint        y, m, d, n, s, q, lin;
        bit            ok;
        r   = '0;
        ok  = 1'b0;
        lin = 0;
        case (item.op)
            OP_DATE: begin
                y = item.year;
                m = item.month;
                d = item.dom;
                if (y >= 1 && y <= YEAR_MAX && m >= 1 && m <= 12 &&
                    d >= 1 && d <= month_days(y, m)) begin
                    lin = days_from_civil(y, m, d);
                    ok  = 1'b1;
                end
            end
            OP_DNUM: begin
                n = $signed(item.dnum);
                if (n != 0) begin
                    lin = (n > 0) ? n - 1 : n;
                    ok  = 1'b1;
                end
            end
            OP_SECS: begin
                // floor division, so an exact negative boundary opens a day
                s = $signed(item.secs);
                q = s / SEC_DAY;
                if (s < 0 && q * SEC_DAY != s) q = q - 1;
                lin = q;
                ok  = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        if (ok && (lin < LIN_FIRST || lin > LIN_LAST)) ok = 1'b0;
        if (ok) begin
            civil_from_days(lin, y, m, d);
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DAY_W'(d);
            r.dnum  = LIN_W'((lin >= 0) ? lin + 1 : lin);
            r.secs  = SEC_W'(lin * SEC_DAY);
            r.ok    = 1'b1;
        end
        return r;
    endfunction

    // ---------------- item builders ----------------

    // Every data field random at full width, op random among the three used codes; callers overwrite what the op uses
    function automatic t_civil_item noise_item();
        t_civil_item item;
        item.op    = OP_W'($urandom_range(0, 2));
        item.year  = YEAR_W'($urandom());
        item.month = MONTH_W'($urandom());
        item.dom   = DAY_W'($urandom());
        item.dnum  = LIN_W'($urandom());
        item.secs  = SEC_W'({$urandom(), $urandom()});
        return item;
    endfunction

    function automatic t_civil_item date_item(input longint y, input longint m,
                                              input longint d);
        t_civil_item item;
        item       = noise_item();
        item.op    = OP_DATE;
        item.year  = YEAR_W'(y);
        item.month = MONTH_W'(m);
        item.dom   = DAY_W'(d);
        return item;
    endfunction

    function automatic t_civil_item dnum_item(input longint n);
        t_civil_item item;
        item      = noise_item();
        item.op   = OP_DNUM;
        item.dnum = LIN_W'(n);
        return item;
    endfunction

    function automatic t_civil_item secs_item(input longint s);
        t_civil_item item;
        item      = noise_item();
        item.op   = OP_SECS;
        item.secs = SEC_W'(s);
        return item;
    endfunction

    // Mostly legal content per operation, some boundaries, some raw noise
    function automatic t_civil_item random_item();
        t_civil_item item;
        longint      y, m, d, lin;
        int          pick, sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 32);
        if (sel == 0) begin
            item    = noise_item();
            item.op = OP_UNUSED;
        end else if (sel <= 11) begin
            if (pick < 80) begin
                // century years exercise the leap exceptions
                if ($urandom_range(0, 3) == 0)
                    y = 400 * $urandom_range(1, 24) - 100 * $urandom_range(0, 3);
                else
                    y = $urandom_range(1, YEAR_MAX);
                m = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0) d = month_days(y, m);
                else d = $urandom_range(1, month_days(y, m));
                item = date_item(y, m, d);
            end else begin
                item    = noise_item();
                item.op = OP_DATE;
            end
        end else if (sel <= 22) begin
            if (pick < 80) begin
                lin  = longint'($urandom_range(0, LIN_LAST - LIN_FIRST)) + LIN_FIRST;
                item = dnum_item((lin >= 0) ? lin + 1 : lin);
            end else if (pick < 90) begin
                case ($urandom_range(0, 6))
                    0:       item = dnum_item(0);
                    1:       item = dnum_item(1);
                    2:       item = dnum_item(-1);
                    3:       item = dnum_item(LIN_FIRST);
                    4:       item = dnum_item(LIN_FIRST - 1);
                    5:       item = dnum_item(LIN_LAST + 1);
                    default: item = dnum_item(LIN_LAST + 2);
                endcase
            end else begin
                item    = noise_item();
                item.op = OP_DNUM;
            end
        end else begin
            if (pick < 75) begin
                lin = longint'($urandom_range(0, LIN_LAST - LIN_FIRST)) + LIN_FIRST;
                case ($urandom_range(0, 3))
                    0:       item = secs_item(lin * SEC_DAY);
                    1:       item = secs_item(lin * SEC_DAY + SEC_DAY - 1);
                    default: item = secs_item(lin * SEC_DAY + $urandom_range(0, SEC_DAY - 1));
                endcase
            end else if (pick < 87) begin
                case ($urandom_range(0, 7))
                    0:       item = secs_item(SEC_FIRST);
                    1:       item = secs_item(SEC_FIRST - 1);
                    2:       item = secs_item(SEC_LAST);
                    3:       item = secs_item(SEC_LAST + 1);
                    4:       item = secs_item(-SEC_DAY);
                    5:       item = secs_item(-SEC_DAY - 1);
                    6:       item = secs_item(-2 * SEC_DAY + 1);
                    default: item = secs_item(SEC_DAY);
                endcase
            end else begin
                item    = noise_item();
                item.op = OP_SECS;
            end
        end
        return item;
    endfunction

    // ---------------- driving ----------------

    // One beat; bursts of back-to-back starts separated by random gaps
    task automatic send_item(input t_civil_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left     = burst_left - 1;
        @(negedge i_clk);
        start          = 1'b1;
        i_operation    = item.op;
        i_year         = item.year;
        i_month        = item.month;
        i_day_of_month = item.dom;
        i_day_number   = item.dnum;
        i_seconds      = item.secs;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_dates.push_back(predict_civil_result(item));
    endtask

    task automatic drop_start();
        @(negedge i_clk);
        start      = 1'b0;
        burst_left = 0;
    endtask

    task automatic drain_results();
        drop_start();
        while (expected_dates.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name,
                                      $signed(got), $signed(want)));
    endtask

    // Result beat is taken at the edge that ends its strobe cycle
    always @(posedge i_clk) begin : check_results
        t_civil_result want;
        if (o_done === 1'b1) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("result beat with no item pending");
            end else begin
                want = expected_dates.pop_front();
                compare_field("valid_res", o_valid_res, want.ok);
                compare_field("year", o_out_year, want.year);
                compare_field("month", o_out_month, want.month);
                compare_field("day", o_out_day, want.day);
                compare_field("day_number", o_out_day_number, want.dnum);
                compare_field("seconds", o_out_seconds, want.secs);
            end
        end
    end

    // Watchdog: too long without any beat in or out
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- tests ----------------

    task automatic test_date_directed();
        send_item(date_item(1970, 1, 1));
        send_item(date_item(1969, 12, 31));
        send_item(date_item(1, 1, 1));
        send_item(date_item(YEAR_MAX, 12, 31));
        send_item(date_item(YEAR_MAX + 1, 1, 1));  // year past the top
        send_item(date_item(0, 6, 15));            // year zero
        send_item(date_item(2000, 2, 29));         // leap by 400 rule
        send_item(date_item(1900, 2, 29));         // century, not leap
        send_item(date_item(2023, 4, 31));         // past a 30-day month
        send_item(date_item(2024, 13, 1));
        send_item(date_item(2024, 3, 0));
    endtask

    task automatic test_day_number_directed();
        send_item(dnum_item(0));
        send_item(dnum_item(1));
        send_item(dnum_item(-1));
        send_item(dnum_item(LIN_FIRST));
        send_item(dnum_item(LIN_FIRST - 1));
        send_item(dnum_item(LIN_LAST + 1));
        send_item(dnum_item(LIN_LAST + 2));
    endtask

    task automatic test_seconds_directed();
        send_item(secs_item(0));
        send_item(secs_item(-1));
        send_item(secs_item(-SEC_DAY));    // exact negative day boundary
        send_item(secs_item(-SEC_DAY - 1));
        send_item(secs_item(SEC_FIRST));
        send_item(secs_item(SEC_LAST));
    endtask

    task automatic test_unused_operation();
        t_civil_item item;
        item    = noise_item();
        item.op = OP_UNUSED;
        send_item(item);
    endtask

    // Sender holds off after every eighth item until the block has returned everything
    task automatic test_drain_pauses();
        for (int i = 0; i < 40; i++) begin
            send_item(random_item());
            if (i % 8 == 7) drain_results();
        end
    endtask

    task automatic test_random_items();
        for (int i = 0; i < 360; i++) send_item(random_item());
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = OP_DATE;
        i_year         = '0;
        i_month        = '0;
        i_day_of_month = '0;
        i_day_number   = '0;
        i_seconds      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_date_directed();
        test_day_number_directed();
        test_seconds_directed();
        test_unused_operation();
        test_drain_pauses();
        test_random_items();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
